// ----- rtl/core/svft_pkg.sv -----
`default_nettype none
package svft_pkg;

    localparam int WORD_W = 32;
    localparam logic [WORD_W-1:0] COUNT_MAX = {WORD_W{1'b1}};

    typedef struct packed {
        logic cmp;
        logic upd;
        logic ins;
        logic rot;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/core/svft_cell.sv -----
`default_nettype none
module svft_cell
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire svft_pkg::cell_ctrl_t           ctrl,
    input  wire logic signed [svft_pkg::WORD_W-1:0] v,
    input  wire                                 occupied,
    input  wire                                 prev_less,
    input  wire logic signed [svft_pkg::WORD_W-1:0] prev_value,
    input  wire logic [svft_pkg::WORD_W-1:0]    prev_count,
    input  wire                                 next_occ,
    input  wire logic signed [svft_pkg::WORD_W-1:0] next_value,
    input  wire logic [svft_pkg::WORD_W-1:0]    next_count,
    input  wire logic signed [svft_pkg::WORD_W-1:0] head_value,
    input  wire logic [svft_pkg::WORD_W-1:0]    head_count,
    output logic signed [svft_pkg::WORD_W-1:0]  value,
    output logic [svft_pkg::WORD_W-1:0]         count,
    output logic                                less,
    output logic                                eq
);

    logic signed [svft_pkg::WORD_W-1:0] value_reg, value_next;
    logic [svft_pkg::WORD_W-1:0]        count_reg, count_next;
    logic                               less_reg, less_next;
    logic                               eq_reg, eq_next;

    always_comb
    begin
        value_next = value_reg;
        count_next = count_reg;
        less_next  = less_reg;
        eq_next    = eq_reg;
        if (ctrl.cmp)
        begin
            less_next = occupied && (value_reg < v);
            eq_next   = occupied && (value_reg == v);
        end
        if (ctrl.upd)
        begin
            if (eq_reg)
            begin
                if (count_reg != svft_pkg::COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else if (ctrl.ins && !less_reg)
            begin
                if (prev_less)
                begin
                    value_next = v;
                    count_next = {{(svft_pkg::WORD_W-1){1'b0}}, 1'b1};
                end
                else
                begin
                    value_next = prev_value;
                    count_next = prev_count;
                end
            end
        end
        if (ctrl.rot && occupied)
        begin
            if (next_occ)
            begin
                value_next = next_value;
                count_next = next_count;
            end
            else
            begin
                value_next = head_value;
                count_next = head_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        count_reg <= count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            less_reg <= 1'b0;
            eq_reg   <= 1'b0;
        end
        else
        begin
            less_reg <= less_next;
            eq_reg   <= eq_next;
        end
    end

    assign value = value_reg;
    assign count = count_reg;
    assign less  = less_reg;
    assign eq    = eq_reg;

endmodule
`default_nettype wire

// ----- rtl/core/sorted_value_frequency_table.sv -----
`default_nettype none
// Sorted frequency table: keeps up to TABLE_ENTRIES distinct signed values in
// ascending order, each with a saturating occurrence count, in a row of cells.
// Each accepted word goes through these steps in order: accept it, let every
// cell compare its entry against the word, increment the match or shift the
// cells above the insertion point up by one, then send one result word per
// entry while the row rotates toward cell 0, which feeds the output register.
// A new value that finds the table full is dropped and the listing carries
// dropped_full. Further words are stalled until the listing has been loaded.
module sorted_value_frequency_table #(
    parameter int TABLE_ENTRIES = 64
)
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 item_valid,
    output logic                                item_stall,
    input  wire logic signed [svft_pkg::WORD_W-1:0] value,
    output logic                                entry_valid,
    input  wire                                 entry_stall,
    output logic signed [svft_pkg::WORD_W-1:0]  entry_value,
    output logic [svft_pkg::WORD_W-1:0]         entry_count,
    output logic                                is_last,
    output logic                                dropped_full
);

    localparam int OCC_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(TABLE_ENTRIES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_LIST = 2'd3;

    logic [1:0]                         state_reg, state_next;
    logic [OCC_W-1:0]                   occ_reg, occ_next;
    logic [OCC_W-1:0]                   cnt_reg, cnt_next;
    logic                               drop_reg, drop_next;
    logic signed [svft_pkg::WORD_W-1:0] v_reg, v_next;
    logic                               ovalid_reg, ovalid_next;
    logic signed [svft_pkg::WORD_W-1:0] oval_reg, oval_next;
    logic [svft_pkg::WORD_W-1:0]        ocnt_reg, ocnt_next;
    logic                               olast_reg, olast_next;
    logic                               odrop_reg, odrop_next;

    svft_pkg::cell_ctrl_t               ctrl;
    logic signed [svft_pkg::WORD_W-1:0] cell_value [TABLE_ENTRIES];
    logic [svft_pkg::WORD_W-1:0]        cell_count [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]           cell_less;
    logic [TABLE_ENTRIES-1:0]           cell_eq;
    logic [TABLE_ENTRIES-1:0]           cell_occ;

    logic found;
    logic full;
    logic load;

    assign found = |cell_eq;
    assign full  = (occ_reg == OCC_FULL);
    assign load  = (state_reg == ST_LIST) && (!ovalid_reg || !entry_stall);

    genvar k;
    generate
        for (k = 0; k < TABLE_ENTRIES; k++)
        begin : g_cell
            assign cell_occ[k] = (occ_reg > OCC_W'(k));

            if (k == 0)
            begin : g_first
                svft_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .v          (v_reg),
                    .occupied   (cell_occ[k]),
                    .prev_less  (1'b1),
                    .prev_value ({svft_pkg::WORD_W{1'b0}}),
                    .prev_count ({svft_pkg::WORD_W{1'b0}}),
                    .next_occ   (cell_occ[k+1]),
                    .next_value (cell_value[k+1]),
                    .next_count (cell_count[k+1]),
                    .head_value (cell_value[0]),
                    .head_count (cell_count[0]),
                    .value      (cell_value[k]),
                    .count      (cell_count[k]),
                    .less       (cell_less[k]),
                    .eq         (cell_eq[k])
                );
            end
            else if (k == TABLE_ENTRIES - 1)
            begin : g_last
                svft_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .v          (v_reg),
                    .occupied   (cell_occ[k]),
                    .prev_less  (cell_less[k-1]),
                    .prev_value (cell_value[k-1]),
                    .prev_count (cell_count[k-1]),
                    .next_occ   (1'b0),
                    .next_value ({svft_pkg::WORD_W{1'b0}}),
                    .next_count ({svft_pkg::WORD_W{1'b0}}),
                    .head_value (cell_value[0]),
                    .head_count (cell_count[0]),
                    .value      (cell_value[k]),
                    .count      (cell_count[k]),
                    .less       (cell_less[k]),
                    .eq         (cell_eq[k])
                );
            end
            else
            begin : g_mid
                svft_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .v          (v_reg),
                    .occupied   (cell_occ[k]),
                    .prev_less  (cell_less[k-1]),
                    .prev_value (cell_value[k-1]),
                    .prev_count (cell_count[k-1]),
                    .next_occ   (cell_occ[k+1]),
                    .next_value (cell_value[k+1]),
                    .next_count (cell_count[k+1]),
                    .head_value (cell_value[0]),
                    .head_count (cell_count[0]),
                    .value      (cell_value[k]),
                    .count      (cell_count[k]),
                    .less       (cell_less[k]),
                    .eq         (cell_eq[k])
                );
            end
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        cnt_next    = cnt_reg;
        drop_next   = drop_reg;
        v_next      = v_reg;
        ovalid_next = ovalid_reg;
        oval_next   = oval_reg;
        ocnt_next   = ocnt_reg;
        olast_next  = olast_reg;
        odrop_next  = odrop_reg;
        ctrl        = '0;

        if (ovalid_reg && !entry_stall)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    v_next     = value;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                ctrl.cmp   = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                ctrl.upd   = 1'b1;
                ctrl.ins   = !found && !full;
                drop_next  = !found && full;
                cnt_next   = '0;
                if (!found && !full)
                begin
                    occ_next = occ_reg + 1'b1;
                end
                state_next = ST_LIST;
            end
            ST_LIST:
            begin
                if (load)
                begin
                    ctrl.rot    = 1'b1;
                    ovalid_next = 1'b1;
                    oval_next   = cell_value[0];
                    ocnt_next   = cell_count[0];
                    olast_next  = (cnt_reg == occ_reg - 1'b1);
                    odrop_next  = drop_reg;
                    cnt_next    = cnt_reg + 1'b1;
                    if (cnt_reg == occ_reg - 1'b1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            occ_reg    <= '0;
            cnt_reg    <= '0;
            drop_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            cnt_reg    <= cnt_next;
            drop_reg   <= drop_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        oval_reg  <= oval_next;
        ocnt_reg  <= ocnt_next;
        olast_reg <= olast_next;
        odrop_reg <= odrop_next;
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign entry_valid  = ovalid_reg;
    assign entry_value  = oval_reg;
    assign entry_count  = ocnt_reg;
    assign is_last      = olast_reg;
    assign dropped_full = odrop_reg;

endmodule
`default_nettype wire
